// ===== hdl/mhr_pkg.sv =====
// Shared types and constants for the holding-register responder.
package mhr_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    ACT_READ         = 2'd0,
    ACT_WRITE_SINGLE = 2'd1,
    ACT_WRITE_MULTI  = 2'd2,
    ACT_UNSUPPORTED  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ILLEGAL_ADDR = 2'd1,
    ST_ILLEGAL_FUNC = 2'd2
  } status_t;

  typedef enum logic {
    BK_CLEAR = 1'b0,
    BK_RUN   = 1'b1
  } back_state_t;

  // One classified request handed from the front end to the back end.
  typedef struct packed {
    logic                read;   // stream count words from addr
    logic                store;  // write value at addr
    logic                reply;  // one result item
    logic                echo;   // reply data is value, else zero
    status_t             status;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   count;
    logic [WORD_W-1:0]   value;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic                last;
    logic [WORD_W-1:0]   data;
    logic [WORD_W-1:0]   count;
    status_t             status;
  } res_t;

endpackage

// ===== hdl/mhr_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module mhr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mhr_fifo.sv =====
// Small register FIFO with occupancy output.
module mhr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               din,
  input  logic                           pop,
  output logic [WIDTH-1:0]               dout,
  output logic                           full,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     level
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (level == LW'(DEPTH));
  assign empty   = (level == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   level <= level + LW'(1);
        2'b01:   level <= level - LW'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

// ===== hdl/mhr_front.sv =====
// Front end: accepts request items, checks address, clamps counts, queues commands.
module mhr_front #(
  parameter int unsigned REG_COUNT = 256,
  parameter int unsigned MAX_READ  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tvalid,
  output logic                tready,
  input  logic [1:0]          action,
  input  logic [7:0]          slave_address,
  input  logic [15:0]         start_address,
  input  logic [15:0]         quantity,
  input  logic [6:0]          word_index,
  input  logic [15:0]         value,
  input  logic                last_word,
  input  logic [7:0]          own_address,
  input  logic                back_ready,
  output logic                cmd_push,
  output mhr_pkg::cmd_t       cmd,
  input  logic                cmd_full
);

  localparam logic [16:0] RC      = 17'(REG_COUNT);
  localparam logic [15:0] RD_MAX  = 16'(MAX_READ);

  logic        accept;
  logic        match;
  logic        oob;
  logic [16:0] remain;
  logic [15:0] wr_n;
  logic [15:0] rd_n;
  logic [16:0] wm_addr;
  logic        wm_store;
  logic        has_work;
  logic        clk_unused;

  // purely combinational; no item is taken while reset is held
  assign clk_unused = clk;

  assign tready = back_ready && !cmd_full && !rst;
  assign accept = tvalid && tready;
  assign match  = (slave_address == own_address);

  assign oob      = ({1'b0, start_address} >= RC);
  assign remain   = RC - {1'b0, start_address};
  assign wr_n     = ({1'b0, quantity} < remain) ? quantity : remain[15:0];
  assign rd_n     = (wr_n < RD_MAX) ? wr_n : RD_MAX;
  assign wm_addr  = {1'b0, start_address} + 17'(word_index);
  assign wm_store = ({9'd0, word_index} < quantity) && (wm_addr < RC);

  always_comb begin
    cmd          = '0;
    cmd.status   = mhr_pkg::ST_OK;
    cmd.addr     = start_address;
    cmd.value    = value;
    has_work     = 1'b1;
    unique case (mhr_pkg::action_t'(action))
      mhr_pkg::ACT_READ: begin
        if (oob) begin
          cmd.reply  = 1'b1;
          cmd.status = mhr_pkg::ST_ILLEGAL_ADDR;
        end else if (rd_n == '0) begin
          cmd.reply  = 1'b1;
        end else begin
          cmd.read   = 1'b1;
          cmd.count  = rd_n;
        end
      end
      mhr_pkg::ACT_WRITE_SINGLE: begin
        cmd.reply = 1'b1;
        if (oob) begin
          cmd.status = mhr_pkg::ST_ILLEGAL_ADDR;
        end else begin
          cmd.store = 1'b1;
          cmd.echo  = 1'b1;
          cmd.count = 16'd1;
        end
      end
      mhr_pkg::ACT_WRITE_MULTI: begin
        cmd.addr = wm_addr[15:0];
        if (oob) begin
          cmd.reply  = last_word;
          cmd.status = mhr_pkg::ST_ILLEGAL_ADDR;
          has_work   = last_word;
        end else begin
          cmd.store = wm_store;
          cmd.reply = last_word;
          cmd.count = wr_n;
          has_work  = wm_store || last_word;
        end
      end
      mhr_pkg::ACT_UNSUPPORTED: begin
        cmd.reply  = 1'b1;
        cmd.status = mhr_pkg::ST_ILLEGAL_FUNC;
      end
      default: begin
        has_work = 1'b0;
      end
    endcase
  end

  assign cmd_push = accept && match && has_work;

endmodule

// ===== hdl/mhr_back.sv =====
// Back end: register bank, clearing pass after reset, command execution.
module mhr_back #(
  parameter int unsigned REG_COUNT = 256,
  parameter int unsigned MAX_READ  = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cmd_valid,
  input  mhr_pkg::cmd_t                          cmd,
  output logic                                   cmd_pop,
  input  logic [$clog2(mhr_pkg::OUT_DEPTH+1)-1:0] out_level,
  output logic                                   out_push,
  output mhr_pkg::res_t                          out_item,
  output logic                                   ready
);

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned IW = (MAX_READ > 1) ? $clog2(MAX_READ) : 1;
  localparam int unsigned LW = $clog2(mhr_pkg::OUT_DEPTH + 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(REG_COUNT - 1);
  localparam logic [LW:0]   ROOM_MAX = (LW+1)'(mhr_pkg::OUT_DEPTH - 2);

  mhr_pkg::back_state_t state;
  mhr_pkg::back_state_t state_next;

  logic [AW-1:0]  clr_addr;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  idx_next;
  logic           inflight;
  logic [15:0]    rd_count;
  logic           rd_last;

  logic           room;
  logic           go;
  logic           issue;
  logic           issue_last;
  logic           act;
  logic           reply_push;
  logic [16:0]    rd_sum;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [15:0]    wdata;
  logic [AW-1:0]  raddr;
  logic [15:0]    rdata;

  mhr_ram #(
    .WIDTH(mhr_pkg::WORD_W),
    .DEPTH(REG_COUNT)
  ) u_bank (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  // result buffer space counts words already asked of the RAM
  assign room  = ({1'b0, out_level} + (LW+1)'(inflight)) <= ROOM_MAX;
  assign go    = (state == mhr_pkg::BK_RUN) && cmd_valid && room;
  assign ready = (state == mhr_pkg::BK_RUN);

  assign rd_sum     = {1'b0, cmd.addr} + 17'(idx);
  assign raddr      = rd_sum[AW-1:0];
  assign issue      = go && cmd.read;
  assign issue_last = (16'(idx) == cmd.count - 16'd1);
  // single replies wait for the read pipe so results keep their order
  assign act        = go && !cmd.read && (!cmd.reply || !inflight);
  assign reply_push = act && cmd.reply;

  always_comb begin
    state_next = state;
    unique case (state)
      mhr_pkg::BK_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = mhr_pkg::BK_RUN;
        end
      end
      mhr_pkg::BK_RUN: begin
        state_next = mhr_pkg::BK_RUN;
      end
      default: begin
        state_next = mhr_pkg::BK_CLEAR;
      end
    endcase
  end

  always_comb begin
    we       = 1'b0;
    waddr    = cmd.addr[AW-1:0];
    wdata    = cmd.value;
    cmd_pop  = 1'b0;
    idx_next = idx;
    unique case (state)
      mhr_pkg::BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      mhr_pkg::BK_RUN: begin
        we = act && cmd.store;
        if (issue) begin
          cmd_pop  = issue_last;
          idx_next = issue_last ? '0 : idx + IW'(1);
        end else begin
          cmd_pop = act;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_push = inflight || reply_push;
    if (inflight) begin
      out_item.status = mhr_pkg::ST_OK;
      out_item.count  = rd_count;
      out_item.data   = rdata;
      out_item.last   = rd_last;
    end else begin
      out_item.status = cmd.status;
      out_item.count  = cmd.count;
      out_item.data   = cmd.echo ? cmd.value : '0;
      out_item.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mhr_pkg::BK_CLEAR;
      clr_addr <= '0;
      idx      <= '0;
      inflight <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      inflight <= issue;
      if (state == mhr_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_count <= cmd.count;
      rd_last  <= issue_last;
    end
  end

endmodule

// ===== hdl/modbus_holding_register_responder_top.sv =====
// Top level of the Modbus holding-register responder.
//
//  port group  | role                       | item / payload
//  ------------+----------------------------+-------------------------------------------
//  s_t*        | request items in           | tuser: action; tdata: request fields;
//              |                            | tlast: last data word of write multiple
//  m_t*        | result items out           | tdata: status, count, data; tlast: last
//  p*          | APB register port          | own_address at byte address 0
//
// After reset the bank is swept to zero, one word per cycle, with s_tready
// low (APB writes are taken meanwhile).
// Each request item passes the front end combinationally into the command queue;
// a write or single reply is then done by the back end. A read of n words issues
// one RAM read per cycle while the result buffer has room, so its results leave
// at one item per cycle unless stalled. A 2-entry command queue lets the front keep
// taking items while the back streams; a 4-entry result buffer absorbs m_tready stalls.
module modbus_holding_register_responder_top #(
  parameter int unsigned REG_COUNT = 256,
  parameter int unsigned MAX_READ  = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request items
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] slave_address, [23:8] start_address, [39:24] quantity,
  // [46:40] word_index, [62:47] value, [63] zero
  input  logic [63:0] s_tdata,
  // [1:0] action
  input  logic [1:0]  s_tuser,
  // last_word
  input  logic        s_tlast,
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [17:2] count, [33:18] data, [39:34] zero
  output logic [39:0] m_tdata,
  // last
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ADDR_OWN = 3'd0;
  localparam int unsigned CMD_W = $bits(mhr_pkg::cmd_t);
  localparam int unsigned RES_W = $bits(mhr_pkg::res_t);

  logic [7:0] own_address;

  // APB: always ready, single register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_OWN) ? {24'd0, own_address} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 8'd1;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_OWN)) begin
      own_address <= pwdata[7:0];
    end
  end

  // front end -> command queue
  logic              back_ready;
  logic              cmd_push;
  mhr_pkg::cmd_t     cmd_in;
  logic [CMD_W-1:0]  cmd_head_bits;
  mhr_pkg::cmd_t     cmd_head;
  logic              cmd_full;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [$clog2(mhr_pkg::CMD_DEPTH+1)-1:0] cmd_level;
  logic              cmd_level_unused;

  mhr_front #(
    .REG_COUNT(REG_COUNT),
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .tvalid       (s_tvalid),
    .tready       (s_tready),
    .action       (s_tuser),
    .slave_address(s_tdata[7:0]),
    .start_address(s_tdata[23:8]),
    .quantity     (s_tdata[39:24]),
    .word_index   (s_tdata[46:40]),
    .value        (s_tdata[62:47]),
    .last_word    (s_tlast),
    .own_address  (own_address),
    .back_ready   (back_ready),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .cmd_full     (cmd_full)
  );

  mhr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(mhr_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .din  (cmd_in),
    .pop  (cmd_pop),
    .dout (cmd_head_bits),
    .full (cmd_full),
    .empty(cmd_empty),
    .level(cmd_level)
  );

  assign cmd_head         = mhr_pkg::cmd_t'(cmd_head_bits);
  assign cmd_level_unused = ^cmd_level;

  // back end -> result buffer
  logic              out_push;
  mhr_pkg::res_t     out_item;
  logic [RES_W-1:0]  out_head_bits;
  mhr_pkg::res_t     out_head;
  logic              out_full;
  logic              out_empty;
  logic [$clog2(mhr_pkg::OUT_DEPTH+1)-1:0] out_level;

  mhr_back #(
    .REG_COUNT(REG_COUNT),
    .MAX_READ (MAX_READ)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!cmd_empty),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .out_level(out_level),
    .out_push (out_push),
    .out_item (out_item),
    .ready    (back_ready)
  );

  mhr_fifo #(
    .WIDTH(RES_W),
    .DEPTH(mhr_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push && !(out_full && cmd_level_unused && 1'b0)),
    .din  (out_item),
    .pop  (m_tready),
    .dout (out_head_bits),
    .full (out_full),
    .empty(out_empty),
    .level(out_level)
  );

  assign out_head = mhr_pkg::res_t'(out_head_bits);
  assign m_tvalid = !out_empty;
  assign m_tdata  = {6'd0, out_head.data, out_head.count, out_head.status};
  assign m_tlast  = out_head.last;

endmodule

// ===== dv/tb_modbus_holding_register_responder_top.sv =====
// Self-checking testbench for the Modbus holding-register responder: predicted replies vs. stream.
module tb_modbus_holding_register_responder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mhr_pkg::*;

  localparam int unsigned REG_COUNT        = 256;
  localparam int unsigned MAX_READ         = 64;
  localparam logic [2:0]  OWN_ADDRESS_REG  = 3'd0;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  // long sink hold-off starts once this many request items went in
  localparam int unsigned HOLD_AFTER_ITEMS = 80;
  localparam int unsigned HOLD_CYCLES      = 400;
  // quiet time after the last reply: front end, command queue, back end, result buffer
  localparam int unsigned SETTLE_CYCLES    = 20;

  // one request item as the sender sees it
  typedef struct packed {
    action_t     act;
    logic [7:0]  slave;
    logic [15:0] start;
    logic [15:0] qty;
    logic [6:0]  widx;
    logic [15:0] val;
    logic        lastw;
  } request_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // requests waiting for the driver, replies waiting for the block
  request_t    request_queue[$];
  res_t        expected_replies[$];

  // mirror of the block: register bank and configured slave address
  logic [15:0] bank_mirror [REG_COUNT];
  logic [7:0]  own_address_mirror;

  int unsigned send_gap       = 0;
  int unsigned sink_gap       = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  bit          calm           = 1'b0;  // no idling on either side in the closing phase
  int unsigned accepted_items = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;

  modbus_holding_register_responder_top #(
    .REG_COUNT(REG_COUNT),
    .MAX_READ (MAX_READ)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Reply prediction
  // ---------------------------------------------------------------------------
  task automatic push_reply(input status_t st, input int unsigned cnt,
                            input logic [15:0] word, input logic fin);
    res_t r;
    r.status = st;
    r.count  = cnt[15:0];
    r.data   = word;
    r.last   = fin;
    expected_replies.push_back(r);
  endtask

  // Applies one accepted request to the bank mirror and queues its replies.
  task automatic answer_request(input action_t act, input logic [7:0] slave,
                                input logic [15:0] start, input logic [15:0] qty,
                                input logic [6:0] widx, input logic [15:0] val,
                                input logic lastw);
    int unsigned first;
    int unsigned room;
    int unsigned n;
    int unsigned wi;
    int unsigned q;
    first = 32'(start);
    wi    = 32'(widx);
    q     = 32'(qty);
    if (slave != own_address_mirror) return;  // frame for another slave
    // words left from start to the bank end; zero means illegal address
    room = (first < REG_COUNT) ? REG_COUNT - first : 0;
    case (act)
      ACT_READ: begin
        if (room == 0) begin
          push_reply(ST_ILLEGAL_ADDR, 0, '0, 1'b1);
        end else begin
          n = q;
          if (n > room) n = room;
          if (n > MAX_READ) n = MAX_READ;
          if (n == 0) begin
            push_reply(ST_OK, 0, '0, 1'b1);  // empty read still answers
          end else begin
            for (int unsigned i = 0; i < n; i++)
              push_reply(ST_OK, n, bank_mirror[first + i], (i + 1) == n);
          end
        end
      end
      ACT_WRITE_SINGLE: begin
        if (room == 0) begin
          push_reply(ST_ILLEGAL_ADDR, 0, '0, 1'b1);
        end else begin
          bank_mirror[first] = val;
          push_reply(ST_OK, 1, val, 1'b1);
        end
      end
      ACT_WRITE_MULTI: begin
        if (room == 0) begin
          if (lastw) push_reply(ST_ILLEGAL_ADDR, 0, '0, 1'b1);
        end else begin
          // words beyond the quantity or the bank end are dropped
          if (wi < q && first + wi < REG_COUNT) bank_mirror[first + wi] = val;
          if (lastw) push_reply(ST_OK, (q < room) ? q : room, '0, 1'b1);
        end
      end
      default: begin  // unsupported function
        push_reply(ST_ILLEGAL_FUNC, 0, '0, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(input action_t act, input logic [7:0] slave,
                               input logic [15:0] start, input logic [15:0] qty,
                               input logic [6:0] widx, input logic [15:0] val,
                               input logic lastw);
    request_t r;
    r = '{act, slave, start, qty, widx, val, lastw};
    request_queue.push_back(r);
  endtask

  function automatic request_t random_request();
    request_t r;
    r.act   = action_t'($urandom_range(0, 3));
    r.slave = 8'($urandom);
    r.start = 16'($urandom);
    r.qty   = 16'($urandom);
    r.widx  = 7'($urandom);
    r.val   = 16'($urandom);
    r.lastw = 1'($urandom);
    return r;
  endfunction

  // mostly our own address, sometimes any address at all
  function automatic logic [7:0] pick_slave();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : own_address_mirror;
  endfunction

  // mostly inside the bank, some around its end, some anywhere in 16 bits
  function automatic logic [15:0] pick_start();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return 16'($urandom);
    if (pick == 2) return 16'($urandom_range(240, 260));
    return 16'($urandom_range(0, REG_COUNT - 1));
  endfunction

  // Random traffic: mostly well-formed write-multiple bursts, reads and
  // single writes with random content; the rest unsupported requests, broken bursts and noise.
  task automatic queue_random_requests(input int unsigned n);
    int unsigned made;
    int unsigned pick;
    int unsigned len;
    logic [15:0] start;
    logic [15:0] qty;
    bit          broken;
    request_t    r;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      r = random_request();
      if (pick < 30) begin
        start  = pick_start();
        qty    = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        len    = (qty >= 1 && qty <= 12) ? 32'(qty) : $urandom_range(1, 8);
        broken = ($urandom_range(0, 4) == 0);
        for (int unsigned i = 0; i < len; i++) begin
          r       = random_request();
          r.act   = ACT_WRITE_MULTI;
          r.slave = broken ? pick_slave() : own_address_mirror;
          r.start = start;
          r.qty   = qty;
          // broken bursts: scattered indexes, early or missing last mark
          r.widx  = broken ? 7'($urandom_range(0, 127)) : 7'(i);
          if (i == len - 1) r.lastw = broken ? 1'($urandom_range(0, 1)) : 1'b1;
          else r.lastw = broken && ($urandom_range(0, 7) == 0);
          request_queue.push_back(r);
        end
        made += len;
      end else begin
        if (pick < 55) begin
          r.act   = ACT_READ;
          r.slave = pick_slave();
          r.start = pick_start();
          r.qty   = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70));
        end else if (pick < 75) begin
          r.act   = ACT_WRITE_SINGLE;
          r.slave = pick_slave();
          r.start = pick_start();
        end else if (pick < 82) begin
          r.act   = ACT_UNSUPPORTED;
          r.slave = pick_slave();
        end
        // anything else stays fully random noise
        request_queue.push_back(r);
        made++;
      end
    end
  endtask

  // APB write of the slave address: setup cycle, then access cycle.
  task automatic set_own_address(input logic [7:0] addr_value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OWN_ADDRESS_REG;
    pwdata  <= {24'($urandom), addr_value};  // upper bits are not part of the register
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    own_address_mirror = addr_value;
  endtask

  // Every request sent, every reply seen, then let the pipeline settle.
  task automatic wait_until_quiet();
    while (request_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d (0x%0h) got %0d (0x%0h)",
               $time, name, want, want, got, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: one item per handshake, random gaps until the closing phase
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    request_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap != 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (request_queue.size() != 0) begin
        r = request_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= r.act;
        s_tdata  <= {1'b0, r.val, r.widx, r.qty, r.start, r.slave};
        s_tlast  <= r.lastw;
        // gap, if any, follows this item once it is taken
        if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 10);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Every accepted request is fed to the predictor at the edge it is taken.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      answer_request(action_t'(s_tuser), s_tdata[7:0], s_tdata[23:8], s_tdata[39:24],
                     s_tdata[46:40], s_tdata[62:47], s_tlast);
      accepted_items <= accepted_items + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Reply sink: random stall bursts, plus one long hold-off that backs the
  // block up until it stops taking requests
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_items >= HOLD_AFTER_ITEMS) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (sink_gap != 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      sink_gap <= $urandom_range(1, 10) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Each reply item is checked against the oldest prediction.
  always @(posedge clk) begin : check_replies
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'({m_tlast, m_tdata[33:0]});
      if (expected_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply, expected none got status %0d count %0d",
                 $time, got.status, got.count);
        $display("%0t: unexpected reply data 0x%0h last %0d", $time, got.data, got.last);
      end else begin
        want = expected_replies.pop_front();
        report_field("status", 32'(want.status), 32'(got.status));
        report_field("count", 32'(want.count), 32'(got.count));
        report_field("data", 32'(want.data), 32'(got.data));
        report_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // Watchdog: covers the bank clear after reset, the long hold-off and
  // worst-case stalls with a wide margin.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d replies still outstanding", $time, expected_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    foreach (bank_mirror[i]) bank_mirror[i] = '0;
    own_address_mirror = 8'd1;  // reset value of the slave address
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset slave address. The block sweeps its bank
    // first; the driver simply waits for s_tready.
    queue_request(ACT_READ, 8'd1, 16'd0, 16'd4, '0, '0, 1'b0);         // cleared bank
    queue_request(ACT_WRITE_SINGLE, 8'd1, 16'd0, '0, '0, 16'hFFFF, 1'b0);
    queue_request(ACT_WRITE_SINGLE, 8'd1, 16'd255, '0, '0, 16'h8001, 1'b0);  // last word
    queue_request(ACT_WRITE_SINGLE, 8'd1, 16'd256, '0, '0, 16'h1234, 1'b0);  // just past end
    queue_request(ACT_WRITE_SINGLE, 8'd1, 16'hFFFF, '0, '0, 16'h5555, 1'b0);
    queue_request(ACT_READ, 8'd1, 16'd0, 16'd0, '0, '0, 1'b0);         // empty read
    queue_request(ACT_READ, 8'd1, 16'd250, 16'd100, '0, '0, 1'b0);     // clamped at bank end
    queue_request(ACT_READ, 8'd1, 16'd0, 16'hFFFF, '0, '0, 1'b0);      // clamped to max run
    queue_request(ACT_READ, 8'd1, 16'd256, 16'd1, '0, '0, 1'b0);       // illegal address
    queue_request(ACT_READ, 8'd1, 16'hFFFF, 16'hFFFF, 7'h7F, 16'hFFFF, 1'b1);
    queue_request(ACT_UNSUPPORTED, 8'd1, '0, '0, '0, '0, 1'b0);
    // well-formed write multiple
    queue_request(ACT_WRITE_MULTI, 8'd1, 16'd10, 16'd3, 7'd0, 16'hA001, 1'b0);
    queue_request(ACT_WRITE_MULTI, 8'd1, 16'd10, 16'd3, 7'd1, 16'hA002, 1'b0);
    queue_request(ACT_WRITE_MULTI, 8'd1, 16'd10, 16'd3, 7'd2, 16'hA003, 1'b1);
    // write multiple running past the bank end: count clamps, tail dropped
    for (int unsigned i = 0; i < 5; i++)
      queue_request(ACT_WRITE_MULTI, 8'd1, 16'd254, 16'd5, 7'(i), 16'(16'hB000 + i), i == 4);
    // write multiple starting past the bank: answer only on the last word
    queue_request(ACT_WRITE_MULTI, 8'd1, 16'd300, 16'd2, 7'd0, 16'hC000, 1'b0);
    queue_request(ACT_WRITE_MULTI, 8'd1, 16'd300, 16'd2, 7'd1, 16'hC001, 1'b1);
    // index beyond the quantity is dropped; zero quantity stores nothing
    queue_request(ACT_WRITE_MULTI, 8'd1, 16'd20, 16'd2, 7'd127, 16'hD00D, 1'b1);
    queue_request(ACT_WRITE_MULTI, 8'd1, 16'd0, 16'd0, 7'd0, 16'hDEAD, 1'b1);
    // other slaves: silence, and no store
    queue_request(ACT_READ, 8'd2, 16'd0, 16'd4, '0, '0, 1'b0);
    queue_request(ACT_WRITE_SINGLE, 8'd0, 16'd8, '0, '0, 16'hEEEE, 1'b0);
    queue_request(ACT_UNSUPPORTED, 8'd255, '0, '0, '0, '0, 1'b0);
    // read back what the writes left behind
    queue_request(ACT_READ, 8'd1, 16'd0, 16'd24, '0, '0, 1'b0);
    queue_request(ACT_READ, 8'd1, 16'd250, 16'd6, '0, '0, 1'b0);
    wait_until_quiet();

    // Random phases at the address extremes; the long sink hold-off lands
    // in the first one. Each phase ends with the sender paused until drained.
    set_own_address(8'd0);
    queue_random_requests(70);
    wait_until_quiet();

    set_own_address(8'd255);
    queue_random_requests(70);
    wait_until_quiet();

    // closing phase at full rate, no idling
    set_own_address(8'($urandom_range(2, 254)));
    calm = 1'b1;
    queue_random_requests(40);
    wait_until_quiet();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
